/* rtl/core/pfan_pkg.sv */
// Shared types and constants for the polygon fan triangulator.
package pfan_pkg;

    // Number of leading corners held for the triangle, quad and fan cases.
    localparam int unsigned HELD_DEPTH = 4;

    // Corner count value that stands for "five or more corners seen".
    localparam logic [2:0] FAN_COUNT = 3'd5;

    // What a corner request asks of the downstream stages.
    typedef enum logic [2:0] {
        KIND_NONE,   // corner is only stored, or a short polygon ends
        KIND_TRI,    // third corner closes a triangle
        KIND_QUAD,   // fourth corner closes a quad: pick the shorter diagonal
        KIND_FAN3,   // fifth corner starts a fan: three triangles
        KIND_FAN1    // later fan corner: one triangle
    } pfan_kind_t;

    // Forward control of one pipeline stage.
    typedef struct packed {
        logic       valid;
        pfan_kind_t kind;
    } pfan_ctrl_t;

endpackage

/* rtl/core/pfan_corner_store.sv */
// Corner store: polygon state, held corners, and the first pipeline register.
module pfan_corner_store #(
    parameter int INDEX_BITS = 24,
    parameter int COORD_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [INDEX_BITS-1:0]                in_index,
    input  logic [2:0][COORD_BITS-1:0]           in_coord,
    input  logic                                 in_last,
    output pfan_pkg::pfan_ctrl_t                 out_ctrl,
    input  logic                                 out_ready,
    output logic [4:0][INDEX_BITS-1:0]           out_vtx,
    output logic [3:0][2:0][COORD_BITS-1:0]      out_pts
);
    import pfan_pkg::*;

    logic [2:0]                  count_reg, count_next;
    logic [INDEX_BITS-1:0]       held_index_reg [HELD_DEPTH];
    logic [2:0][COORD_BITS-1:0]  held_coord_reg [HELD_DEPTH];
    logic [INDEX_BITS-1:0]       prev_index_reg;
    logic                        valid_reg;
    pfan_kind_t                  kind_reg, kind_next;
    logic [4:0][INDEX_BITS-1:0]  vtx_reg, vtx_next;
    logic [3:0][2:0][COORD_BITS-1:0] pts_reg;
    logic                        accept;
    logic                        store_corner;
    logic                        fan_corner;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        kind_next    = KIND_NONE;
        store_corner = 1'b0;
        fan_corner   = 1'b0;
        count_next   = count_reg;
        vtx_next     = '0;
        priority if (count_reg < 3'(HELD_DEPTH)) begin
            if (in_last && count_reg == 3'd2) begin
                kind_next   = KIND_TRI;
                vtx_next[0] = held_index_reg[0];
                vtx_next[1] = held_index_reg[1];
                vtx_next[2] = in_index;
            end else if (in_last && count_reg == 3'd3) begin
                kind_next   = KIND_QUAD;
                vtx_next[0] = held_index_reg[0];
                vtx_next[1] = held_index_reg[1];
                vtx_next[2] = held_index_reg[2];
                vtx_next[3] = in_index;
            end else if (!in_last) begin
                store_corner = 1'b1;
                count_next   = count_reg + 3'd1;
            end
        end else if (count_reg == 3'(HELD_DEPTH)) begin
            kind_next   = KIND_FAN3;
            fan_corner  = 1'b1;
            count_next  = FAN_COUNT;
            vtx_next[0] = held_index_reg[0];
            vtx_next[1] = held_index_reg[1];
            vtx_next[2] = held_index_reg[2];
            vtx_next[3] = held_index_reg[3];
            vtx_next[4] = in_index;
        end else begin
            kind_next   = KIND_FAN1;
            fan_corner  = 1'b1;
            count_next  = FAN_COUNT;
            vtx_next[0] = held_index_reg[0];
            vtx_next[1] = prev_index_reg;
            vtx_next[2] = in_index;
        end
        if (in_last) begin
            count_next = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= 3'd0;
            prev_index_reg <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
                if (fan_corner) begin
                    prev_index_reg <= in_index;
                end
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    // Held corners and stage payload carry no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (store_corner) begin
                held_index_reg[count_reg[1:0]] <= in_index;
                held_coord_reg[count_reg[1:0]] <= in_coord;
            end
            kind_reg   <= kind_next;
            vtx_reg    <= vtx_next;
            pts_reg[0] <= held_coord_reg[0];
            pts_reg[1] <= held_coord_reg[1];
            pts_reg[2] <= held_coord_reg[2];
            pts_reg[3] <= in_coord;
        end
    end

    assign out_ctrl.valid = valid_reg;
    assign out_ctrl.kind  = kind_reg;
    assign out_vtx        = vtx_reg;
    assign out_pts        = pts_reg;

endmodule

/* rtl/core/pfan_diag_square.sv */
// Diagonal squares: per-axis squared differences for both quad diagonals.
module pfan_diag_square #(
    parameter int COORD_BITS = 16
) (
    input  logic [3:0][2:0][COORD_BITS-1:0]      in_pts,
    output logic [2:0][2*COORD_BITS:0]           out_sq02,
    output logic [2:0][2*COORD_BITS:0]           out_sq13
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS + 1;

    // A difference magnitude stays below 2**COORD_BITS, so its square fits SQ_W bits.
    always_comb begin
        logic signed [DIFF_W-1:0]   d02;
        logic signed [DIFF_W-1:0]   d13;
        logic signed [2*DIFF_W-1:0] p02;
        logic signed [2*DIFF_W-1:0] p13;
        for (int k = 0; k < 3; k++) begin
            d02 = DIFF_W'($signed(in_pts[0][k])) - DIFF_W'($signed(in_pts[2][k]));
            d13 = DIFF_W'($signed(in_pts[1][k])) - DIFF_W'($signed(in_pts[3][k]));
            p02 = d02 * d02;
            p13 = d13 * d13;
            out_sq02[k] = p02[SQ_W-1:0];
            out_sq13[k] = p13[SQ_W-1:0];
        end
    end

endmodule

/* rtl/core/pfan_tri_queue.sv */
// Triangle queue: diagonal choice, triangle assembly and the output burst register.
module pfan_tri_queue #(
    parameter int INDEX_BITS = 24,
    parameter int COORD_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pfan_pkg::pfan_ctrl_t                 in_ctrl,
    output logic                                 in_ready,
    input  logic [4:0][INDEX_BITS-1:0]           in_vtx,
    input  logic [2:0][2*COORD_BITS:0]           in_sq02,
    input  logic [2:0][2*COORD_BITS:0]           in_sq13,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0][INDEX_BITS-1:0]           out_tri,
    output logic                                 out_last
);
    import pfan_pkg::*;

    localparam int SQ_W  = 2 * COORD_BITS + 1;
    localparam int SUM_W = SQ_W + 2;

    logic [2:0][INDEX_BITS-1:0] tri_reg  [3];
    logic [2:0][INDEX_BITS-1:0] tri_next [3];
    logic [1:0]                 cnt_reg, cnt_next;
    logic [SUM_W-1:0]           sum02, sum13;
    logic                       near02;
    logic                       pop;
    logic                       load;

    assign sum02 = SUM_W'(in_sq02[0]) + SUM_W'(in_sq02[1]) + SUM_W'(in_sq02[2]);
    assign sum13 = SUM_W'(in_sq13[0]) + SUM_W'(in_sq13[1]) + SUM_W'(in_sq13[2]);
    // Strict compare: a tie takes the second diagonal.
    assign near02 = sum02 < sum13;

    always_comb begin
        cnt_next    = 2'd0;
        tri_next[0] = '0;
        tri_next[1] = '0;
        tri_next[2] = '0;
        unique case (in_ctrl.kind)
            KIND_TRI, KIND_FAN1: begin
                cnt_next    = 2'd1;
                tri_next[0] = {in_vtx[2], in_vtx[1], in_vtx[0]};
            end
            KIND_QUAD: begin
                cnt_next = 2'd2;
                if (near02) begin
                    tri_next[0] = {in_vtx[2], in_vtx[1], in_vtx[0]};
                    tri_next[1] = {in_vtx[3], in_vtx[2], in_vtx[0]};
                end else begin
                    tri_next[0] = {in_vtx[3], in_vtx[2], in_vtx[1]};
                    tri_next[1] = {in_vtx[0], in_vtx[3], in_vtx[1]};
                end
            end
            KIND_FAN3: begin
                cnt_next    = 2'd3;
                tri_next[0] = {in_vtx[2], in_vtx[1], in_vtx[0]};
                tri_next[1] = {in_vtx[3], in_vtx[2], in_vtx[0]};
                tri_next[2] = {in_vtx[4], in_vtx[3], in_vtx[0]};
            end
            default: begin
                cnt_next = 2'd0;
            end
        endcase
    end

    assign pop      = out_valid && out_ready;
    // A burst is loaded only once the previous one is gone or leaving.
    assign in_ready = (in_ctrl.kind == KIND_NONE) || (cnt_reg == 2'd0)
                      || (cnt_reg == 2'd1 && out_ready);
    assign load     = in_ctrl.valid && in_ready && (cnt_next != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= cnt_next;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tri_reg[0] <= tri_next[0];
            tri_reg[1] <= tri_next[1];
            tri_reg[2] <= tri_next[2];
        end else if (pop) begin
            tri_reg[0] <= tri_reg[1];
            tri_reg[1] <= tri_reg[2];
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign out_tri   = tri_reg[0];
    assign out_last  = cnt_reg == 2'd1;

endmodule

/* rtl/core/polygon_fan_triangulator_top.sv */
// Top level of the polygon fan triangulator.
//
// The block takes the corners of one polygon, one request per corner, and
// returns triangles as triples of vertex indices. A polygon of one or two
// corners gives nothing, a triangle passes through, a quad is split along
// its shorter diagonal (exact squared distances, strict less-than, so a tie
// splits along the second-to-fourth diagonal), and five or more corners are
// fanned from the first corner. The fifth corner releases three triangles
// at once; each later corner releases one. The last triangle caused by a
// corner carries m_axis_tlast. Corners are accepted one per cycle while the
// input is not stalled. Each corner passes through two registers (corner
// store, triangle burst register) with the diagonal squares, their sums and
// the compare worked out combinationally between them, so its first
// triangle is offered once the burst register has taken it. The output port
// delivers one triangle per cycle while m_axis_tready is high, so sustained
// throughput is one corner per cycle whenever each corner yields at most
// one triangle; a fan start occupies the burst register until its three
// triangles have left and a quad until its two have. During that time
// corners that produce nothing still flow through, while the first corner
// that produces a triangle waits in the corner store and stalls the input.
// Ready flows back combinationally from m_axis_tready through both stages.
module polygon_fan_triangulator_top #(
    parameter int INDEX_BITS = 24,
    parameter int COORD_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // Corner requests.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata fields from bit 0 up: vertex_index, vertex_x, vertex_y, vertex_z, zero pad.
    input  logic [((INDEX_BITS + 3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tlast carries last_corner.
    input  logic s_axis_tlast,
    // Triangle requests.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata fields from bit 0 up: tri_a, tri_b, tri_c, zero pad.
    output logic [((3 * INDEX_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // tlast carries last_of_run.
    output logic m_axis_tlast
);
    import pfan_pkg::*;

    localparam int OUT_W = ((3 * INDEX_BITS + 7) / 8) * 8;

    logic [INDEX_BITS-1:0]           in_index;
    logic [2:0][COORD_BITS-1:0]      in_coord;

    pfan_ctrl_t                      st1_ctrl;
    logic                            st1_ready;
    logic [4:0][INDEX_BITS-1:0]      st1_vtx;
    logic [3:0][2:0][COORD_BITS-1:0] st1_pts;

    logic [2:0][2*COORD_BITS:0]      diag_sq02;
    logic [2:0][2*COORD_BITS:0]      diag_sq13;

    logic [2:0][INDEX_BITS-1:0]      out_tri;

    // Unpack the corner fields from the stream word.
    assign in_index    = s_axis_tdata[INDEX_BITS-1:0];
    assign in_coord[0] = s_axis_tdata[INDEX_BITS +: COORD_BITS];
    assign in_coord[1] = s_axis_tdata[INDEX_BITS + COORD_BITS +: COORD_BITS];
    assign in_coord[2] = s_axis_tdata[INDEX_BITS + 2 * COORD_BITS +: COORD_BITS];

    // Polygon state and held corners; classifies each corner request.
    pfan_corner_store #(
        .INDEX_BITS (INDEX_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_corner_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_index  (in_index),
        .in_coord  (in_coord),
        .in_last   (s_axis_tlast),
        .out_ctrl  (st1_ctrl),
        .out_ready (st1_ready),
        .out_vtx   (st1_vtx),
        .out_pts   (st1_pts)
    );

    // Squared axis differences of both quad diagonals, taken straight from
    // the corner store register.
    pfan_diag_square #(
        .COORD_BITS (COORD_BITS)
    ) u_diag_square (
        .in_pts   (st1_pts),
        .out_sq02 (diag_sq02),
        .out_sq13 (diag_sq13)
    );

    // Diagonal choice and the triangle burst register that drives the output.
    pfan_tri_queue #(
        .INDEX_BITS (INDEX_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_tri_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (st1_ctrl),
        .in_ready  (st1_ready),
        .in_vtx    (st1_vtx),
        .in_sq02   (diag_sq02),
        .in_sq13   (diag_sq13),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_tri   (out_tri),
        .out_last  (m_axis_tlast)
    );

    // Index a sits in the lowest bits; the pad above tri_c is zero.
    assign m_axis_tdata = OUT_W'(out_tri);

endmodule

/* test/tb_polygon_fan_triangulator_top.sv */
// Self-checking testbench for the polygon fan triangulator top level.
module tb_polygon_fan_triangulator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfan_pkg::*;

    // Widths of this build and the packed stream words that follow from them.
    localparam int IDX_W = 24;
    localparam int XYZ_W = 16;
    localparam int S_W   = ((IDX_W + 3 * XYZ_W + 7) / 8) * 8;
    localparam int M_W   = ((3 * IDX_W + 7) / 8) * 8;

    // A corner passes two registers before its first triangle is offered,
    // so DRAIN_CYCLES covers anything still in flight.
    localparam int DRAIN_CYCLES = 8;
    // Longest receiver hold-off used by the back-pressure test.
    localparam int HOLD_CYCLES  = 150;
    // Cycles without any handshake before the run is declared hung. This is
    // many times the hold-off plus the longest random gaps on both sides.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cap on mismatch lines so a broken build does not flood the log.
    localparam int MAX_REPORTS = 60;

    typedef struct packed {
        logic signed [XYZ_W-1:0] x;
        logic signed [XYZ_W-1:0] y;
        logic signed [XYZ_W-1:0] z;
    } corner_xyz_t;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic             run_end;
    } tri_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    // tdata fields from bit 0 up: vertex_index, vertex_x, vertex_y, vertex_z.
    logic [S_W-1:0] s_axis_tdata  = '0;
    // tlast carries last_corner.
    logic           s_axis_tlast  = 1'b0;

    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // tdata fields from bit 0 up: tri_a, tri_b, tri_c.
    logic [M_W-1:0] m_axis_tdata;
    // tlast carries last_of_run.
    logic           m_axis_tlast;

    polygon_fan_triangulator_top #(
        .INDEX_BITS(IDX_W),
        .COORD_BITS(XYZ_W)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle rates in percent per cycle for the corner sender and the
    // triangle receiver. The test sequence changes them between phases.
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // The test bumps hold_req to ask for one long receiver hold-off; the
    // receiver process notices the change and counts the stall itself.
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int corners_sent   = 0;
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------
    // Triangle predictor: its own copy of the corner store and fan state.
    // ------------------------------------------------------------------
    tri_t             tri_expect_q[$];
    logic [2:0]       fan_corners = '0;
    logic [IDX_W-1:0] first_idx[HELD_DEPTH];
    corner_xyz_t      first_xyz[HELD_DEPTH];
    logic [IDX_W-1:0] fan_prev_idx = '0;

    function automatic tri_t make_tri(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                      logic [IDX_W-1:0] c);
        tri_t t;
        t.a = a;
        t.b = b;
        t.c = c;
        t.run_end = 1'b0;
        return t;
    endfunction

    // Exact squared distance; three 17-bit differences squared fit easily.
    function automatic longint unsigned span_sq(corner_xyz_t p, corner_xyz_t q);
        longint dx, dy, dz;
        dx = longint'(p.x) - longint'(q.x);
        dy = longint'(p.y) - longint'(q.y);
        dz = longint'(p.z) - longint'(q.z);
        return unsigned'(dx * dx + dy * dy + dz * dz);
    endfunction

    task automatic triangulate_corner(input logic [IDX_W-1:0] idx, input corner_xyz_t xyz,
                                      input logic last);
        tri_t burst[$];
        longint unsigned d02, d13;
        if (fan_corners < HELD_DEPTH) begin
            if (last && fan_corners == 3'd2) begin
                burst = {burst, make_tri(first_idx[0], first_idx[1], idx)};
            end else if (last && fan_corners == 3'd3) begin
                // Quad: strict compare, so a tie goes to the second diagonal.
                d02 = span_sq(first_xyz[0], first_xyz[2]);
                d13 = span_sq(first_xyz[1], xyz);
                if (d02 < d13) begin
                    burst = {burst, make_tri(first_idx[0], first_idx[1], first_idx[2])};
                    burst = {burst, make_tri(first_idx[0], first_idx[2], idx)};
                end else begin
                    burst = {burst, make_tri(first_idx[1], first_idx[2], idx)};
                    burst = {burst, make_tri(first_idx[1], idx, first_idx[0])};
                end
            end else if (!last) begin
                first_idx[fan_corners[1:0]] = idx;
                first_xyz[fan_corners[1:0]] = xyz;
                fan_corners = fan_corners + 3'd1;
            end
        end else if (fan_corners == HELD_DEPTH) begin
            // Fifth corner: the polygon is no quad, so the fan starts at once.
            burst = {burst, make_tri(first_idx[0], first_idx[1], first_idx[2])};
            burst = {burst, make_tri(first_idx[0], first_idx[2], first_idx[3])};
            burst = {burst, make_tri(first_idx[0], first_idx[3], idx)};
            fan_prev_idx = idx;
            fan_corners  = FAN_COUNT;
        end else begin
            burst = {burst, make_tri(first_idx[0], fan_prev_idx, idx)};
            fan_prev_idx = idx;
            fan_corners  = FAN_COUNT;
        end
        if (last)
            fan_corners = '0;
        if (burst.size() > 0)
            burst[burst.size() - 1].run_end = 1'b1;
        tri_expect_q = {tri_expect_q, burst};
    endtask

    // ------------------------------------------------------------------
    // Checking and reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Every accepted triangle is compared with the oldest one predicted.
    always @(posedge aclk) begin
        tri_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (tri_expect_q.size() == 0) begin
                report_mismatch("unexpected triangle", 32'(m_axis_tdata[IDX_W-1:0]), '0);
            end else begin
                want = tri_expect_q.pop_front();
                if (m_axis_tdata[IDX_W-1:0] !== want.a)
                    report_mismatch("tri_a", 32'(m_axis_tdata[IDX_W-1:0]), 32'(want.a));
                if (m_axis_tdata[2*IDX_W-1:IDX_W] !== want.b)
                    report_mismatch("tri_b", 32'(m_axis_tdata[2*IDX_W-1:IDX_W]),
                                    32'(want.b));
                if (m_axis_tdata[3*IDX_W-1:2*IDX_W] !== want.c)
                    report_mismatch("tri_c", 32'(m_axis_tdata[3*IDX_W-1:2*IDX_W]),
                                    32'(want.c));
                if (m_axis_tlast !== want.run_end)
                    report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want.run_end));
            end
        end
    end

    // The run is hung if neither side completes a request for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Triangle receiver: random stalls and the long hold-off the
    // back-pressure test asks for.
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Corner sender. Entered and left at a falling edge; tvalid stays high
    // on return so back-to-back corners need no second assignment.
    // ------------------------------------------------------------------
    task automatic send_corner(input logic [IDX_W-1:0] idx, input corner_xyz_t xyz,
                               input logic last);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {xyz.z, xyz.y, xyz.x, idx};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        triangulate_corner(idx, xyz, last);
        corners_sent++;
        @(negedge aclk);
    endtask

    // Stop offering corners and wait until every predicted triangle is back.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (tri_expect_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic corner_xyz_t xyz_of(int x, int y, int z);
        corner_xyz_t p;
        p.x = x[XYZ_W-1:0];
        p.y = y[XYZ_W-1:0];
        p.z = z[XYZ_W-1:0];
        return p;
    endfunction

    // Coordinates in one of several flavors: full range, a tiny range that
    // makes diagonal ties common, or only the two extremes, zero and minus one.
    function automatic logic signed [XYZ_W-1:0] pick_coord(int flavor);
        case (flavor)
            2: begin
                return XYZ_W'($urandom_range(0, 4) - 2);
            end
            3: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(XYZ_W-1){1'b0}}};
                    1: return {1'b0, {(XYZ_W-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                return XYZ_W'($urandom());
            end
        endcase
    endfunction

    task automatic send_random_polygon(input int n_corners);
        int flavor;
        corner_xyz_t p;
        flavor = $urandom_range(0, 3);
        for (int k = 0; k < n_corners; k++) begin
            p.x = pick_coord(flavor);
            p.y = pick_coord(flavor);
            p.z = pick_coord(flavor);
            send_corner(IDX_W'($urandom()), p, k == n_corners - 1);
        end
    endtask

    // Polygon sizes lean toward quads and fans, where the logic is richest.
    function automatic int pick_polygon_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom_range(1, 2);
        else if (r < 23)
            return 3;
        else if (r < 55)
            return 4;
        else if (r < 90)
            return $urandom_range(5, 8);
        else
            return $urandom_range(9, 20);
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Polygons of one and two corners produce no triangles.
    task automatic test_short_polygons();
        send_corner(24'h000001, xyz_of(0, 0, 0), 1'b1);
        send_corner(24'h000002, xyz_of(100, -100, 7), 1'b0);
        send_corner(24'h000003, xyz_of(-5, 5, 9), 1'b1);
        wait_for_idle();
    endtask

    // A triangle passes through, here with the extreme index values.
    task automatic test_triangle();
        send_corner(24'h000000, xyz_of(-32768, 32767, 0), 1'b0);
        send_corner(24'hFFFFFF, xyz_of(32767, -32768, -1), 1'b0);
        send_corner(24'hA5A55A, xyz_of(1, 2, 3), 1'b1);
        wait_for_idle();
    endtask

    // Quads split on each diagonal, plus an exact tie at full coordinate span.
    task automatic test_quad_split();
        // First diagonal clearly shorter.
        send_corner(24'h100000, xyz_of(0, 0, 0), 1'b0);
        send_corner(24'h100001, xyz_of(1000, 0, 0), 1'b0);
        send_corner(24'h100002, xyz_of(10, 10, 0), 1'b0);
        send_corner(24'h100003, xyz_of(-1000, 0, 0), 1'b1);
        // Second diagonal clearly shorter.
        send_corner(24'h200000, xyz_of(0, 0, 0), 1'b0);
        send_corner(24'h200001, xyz_of(5, 5, 5), 1'b0);
        send_corner(24'h200002, xyz_of(3000, -3000, 100), 1'b0);
        send_corner(24'h200003, xyz_of(6, 5, 5), 1'b1);
        // Both diagonals span the whole range on every axis: a tie.
        send_corner(24'h300000, xyz_of(-32768, -32768, -32768), 1'b0);
        send_corner(24'h300001, xyz_of(32767, -32768, 32767), 1'b0);
        send_corner(24'h300002, xyz_of(32767, 32767, 32767), 1'b0);
        send_corner(24'h300003, xyz_of(-32768, 32767, -32768), 1'b1);
        wait_for_idle();
    endtask

    // Six corners: the fifth releases three triangles, the sixth one more.
    task automatic test_fan();
        for (int k = 0; k < 6; k++)
            send_corner(IDX_W'(24'h400000 + k), xyz_of(k * 300, -k * 200, k), k == 5);
        wait_for_idle();
    endtask

    task automatic test_random_traffic(input int n_corners);
        int start;
        start = corners_sent;
        while (corners_sent - start < n_corners)
            send_random_polygon(pick_polygon_size());
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch while corners keep coming,
    // so the stages fill up and the block must stall its input.
    task automatic test_output_holdoff();
        send_idle_pct = 0;
        hold_req++;
        send_random_polygon(12);
        send_random_polygon(4);
        send_random_polygon(5);
        send_random_polygon(7);
        wait_for_idle();
    endtask

    // The sender stops mid-stream until every triangle is back, then the
    // next polygon starts from an empty pipeline.
    task automatic test_pause_drain();
        send_random_polygon(9);
        wait_for_idle();
        send_random_polygon(4);
        send_random_polygon(5);
        wait_for_idle();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_short_polygons();
        test_triangle();
        test_quad_split();
        test_fan();

        send_idle_pct = 22;
        recv_idle_pct = 59;
        test_random_traffic(100);

        test_output_holdoff();

        send_idle_pct = 59;
        recv_idle_pct = 22;
        test_random_traffic(100);

        test_pause_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100);

        wait_for_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
